FILE: hw/rtl/hafr_pkg.sv
// ----------------------------------------------------------------------------
// hafr_pkg
// Shared constants, codes, types and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hafr_pkg;

    localparam int HEAP_BYTES   = 16384;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam int ZONE_BYTES   = 4;
    localparam int WORD_BITS    = 32;
    localparam int HEAP_WORDS   = HEAP_BYTES / 4;
    localparam int OFF_W        = $clog2(HEAP_BYTES);
    localparam int IDX_W        = $clog2(HEAP_WORDS);
    localparam int TOP_W        = OFF_W + 1;
    localparam int WIDE_W       = WORD_BITS + 2;
    localparam int TYPE_W       = 3;
    localparam int STAT_W       = 2;

    localparam logic [WORD_BITS-1:0] RED_ZONE = 32'h0102_0304;

    localparam logic [TYPE_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE    = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_REALLOC = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_WRITE   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READ    = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_RESET   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMEM    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DAMAGED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd3;

    typedef struct packed {
        logic                 re;
        logic [IDX_W-1:0]     raddr;
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [WORD_BITS-1:0] wdata;
    } mem_req_t;

    function automatic logic [TOP_W-1:0] round_payload(input logic [OFF_W-1:0] n);
        logic [TOP_W-1:0] s;
        s = {1'b0, n} + TOP_W'(ZONE_BYTES + ALIGN_BYTES - 1);
        return s & ~TOP_W'(ALIGN_BYTES - 1);
    endfunction

    function automatic logic [IDX_W-1:0] word_idx(input logic [OFF_W-1:0] off);
        return off[OFF_W-1:2];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hafr_req_if.sv
// ----------------------------------------------------------------------------
// hafr_req_if
// Request channel of the heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface hafr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [hafr_pkg::TYPE_W-1:0]          req_type;
    logic [hafr_pkg::OFF_W-1:0]           address;
    logic [hafr_pkg::OFF_W-1:0]           size;
    logic [hafr_pkg::WORD_BITS-1:0]       write_data;

    modport source (output valid, req_type, address, size, write_data, input ready);
    modport sink (input valid, req_type, address, size, write_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hafr_rsp_if.sv
// ----------------------------------------------------------------------------
// hafr_rsp_if
// Response channel of the heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface hafr_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [hafr_pkg::STAT_W-1:0]          status;
    logic [hafr_pkg::OFF_W-1:0]           result_address;
    logic [hafr_pkg::WORD_BITS-1:0]       read_data;
    logic [hafr_pkg::WORD_BITS-1:0]       leading_zone;
    logic [hafr_pkg::WORD_BITS-1:0]       trailing_zone;
    logic [hafr_pkg::OFF_W-1:0]           request_bytes;

    modport source (output valid, status, result_address, read_data, leading_zone,
                    trailing_zone, request_bytes, input ready);
    modport sink (input valid, status, result_address, read_data, leading_zone,
                  trailing_zone, request_bytes, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hafr_cfg_if.sv
// ----------------------------------------------------------------------------
// hafr_cfg_if
// Configuration write channel carrying the heap limit.
// ----------------------------------------------------------------------------
`default_nettype none

interface hafr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hafr_pkg::TOP_W-1:0]   heap_limit;

    modport source (output valid, heap_limit, input ready);
    modport sink (input valid, heap_limit, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hafr_mem.sv
// ----------------------------------------------------------------------------
// hafr_mem
// Heap word memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hafr_mem (
    input  wire logic                           clk,
    input  wire hafr_pkg::mem_req_t             mreq,
    output logic [hafr_pkg::WORD_BITS-1:0]      rdata
);

    logic [hafr_pkg::WORD_BITS-1:0] mem [hafr_pkg::HEAP_WORDS];
    logic [hafr_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        if (mreq.re)
        begin
            rdata_reg <= mem[mreq.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/heap_allocator_first_fit_redzone.sv
// ----------------------------------------------------------------------------
// heap_allocator_first_fit_redzone
// First-fit heap allocator with in-band headers and red zones.
// ----------------------------------------------------------------------------
// One request is handled at a time; the response sits in an output register
// so the next request is taken while it waits. Alloc, free and realloc walk
// block headers in the heap memory, which has one read port, visiting one
// header at a time, and then update the headers. A moving realloc copies the
// payload byte by byte. No clearing pass runs after reset.
`default_nettype none

module heap_allocator_first_fit_redzone (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hafr_req_if.sink    req,
    hafr_rsp_if.source  rsp,
    hafr_cfg_if.sink    cfg
);

    localparam int OW = hafr_pkg::OFF_W;
    localparam int TW = hafr_pkg::TOP_W;
    localparam int WW = hafr_pkg::WIDE_W;
    localparam int DW = hafr_pkg::WORD_BITS;
    localparam int HB = hafr_pkg::HEADER_BYTES;
    localparam int ZB = hafr_pkg::ZONE_BYTES;

    localparam logic [5:0] S_IDLE     = 6'd0;
    localparam logic [5:0] S_DISP     = 6'd1;
    localparam logic [5:0] S_RD       = 6'd2;
    localparam logic [5:0] S_FIN      = 6'd3;
    localparam logic [5:0] S_AL_START = 6'd4;
    localparam logic [5:0] S_AL_CHK   = 6'd5;
    localparam logic [5:0] S_AL_SZ    = 6'd6;
    localparam logic [5:0] S_AL_ST    = 6'd7;
    localparam logic [5:0] S_SP1      = 6'd8;
    localparam logic [5:0] S_SP2      = 6'd9;
    localparam logic [5:0] S_SP3      = 6'd10;
    localparam logic [5:0] S_AL_W8    = 6'd11;
    localparam logic [5:0] S_AL_W4    = 6'd12;
    localparam logic [5:0] S_AL_W28   = 6'd13;
    localparam logic [5:0] S_AL_WT    = 6'd14;
    localparam logic [5:0] S_FR_START = 6'd15;
    localparam logic [5:0] S_FR_LEAD  = 6'd16;
    localparam logic [5:0] S_FR_SIZE  = 6'd17;
    localparam logic [5:0] S_FR_TRAIL = 6'd18;
    localparam logic [5:0] S_FR_REQ   = 6'd19;
    localparam logic [5:0] S_FR_STAT  = 6'd20;
    localparam logic [5:0] S_FR_CHK   = 6'd21;
    localparam logic [5:0] S_FR_NS    = 6'd22;
    localparam logic [5:0] S_FR_NSZ   = 6'd23;
    localparam logic [5:0] S_FR_WH    = 6'd24;
    localparam logic [5:0] S_FR_W4    = 6'd25;
    localparam logic [5:0] S_RA_START = 6'd26;
    localparam logic [5:0] S_RA_STAT  = 6'd27;
    localparam logic [5:0] S_RA_SIZE  = 6'd28;
    localparam logic [5:0] S_RA_CHK   = 6'd29;
    localparam logic [5:0] S_RA_NS    = 6'd30;
    localparam logic [5:0] S_RA_NSZ   = 6'd31;
    localparam logic [5:0] S_RA_DEC   = 6'd32;
    localparam logic [5:0] S_RA_WH    = 6'd33;
    localparam logic [5:0] S_RA_WT    = 6'd34;
    localparam logic [5:0] S_RA_W8    = 6'd35;
    localparam logic [5:0] S_CP_RLEN  = 6'd36;
    localparam logic [5:0] S_CP_LEN   = 6'd37;
    localparam logic [5:0] S_CP_CHK   = 6'd38;
    localparam logic [5:0] S_CP_SRC   = 6'd39;
    localparam logic [5:0] S_CP_DST   = 6'd40;

    logic [5:0]                        state_reg, state_next;
    logic [hafr_pkg::TYPE_W-1:0]       op_reg, op_next;
    logic [OW-1:0]                     addr_reg, addr_next;
    logic [OW-1:0]                     size_reg, size_next;
    logic [DW-1:0]                     wdata_reg, wdata_next;
    logic [TW-1:0]                     top_reg, top_next;
    logic [TW-1:0]                     limit_reg, limit_next;
    logic [WW-1:0]                     t_reg, t_next;
    logic [WW-1:0]                     ptr_reg, ptr_next;
    logic [OW-1:0]                     h_reg, h_next;
    logic [DW-1:0]                     sz_reg, sz_next;
    logic [DW-1:0]                     cur_reg, cur_next;
    logic                              mv_reg, mv_next;
    logic                              inpl_reg, inpl_next;
    logic [OW-1:0]                     naddr_reg, naddr_next;
    logic [TW-1:0]                     len_reg, len_next;
    logic [TW-1:0]                     i_reg, i_next;
    logic [7:0]                        byte_reg, byte_next;
    logic [hafr_pkg::STAT_W-1:0]       st_reg, st_next;
    logic [OW-1:0]                     ra_reg, ra_next;
    logic [DW-1:0]                     rd_reg, rd_next;
    logic [DW-1:0]                     lead_reg, lead_next;
    logic [DW-1:0]                     trail_reg, trail_next;
    logic [OW-1:0]                     reqb_reg, reqb_next;
    logic                              ovalid_reg, ovalid_next;
    logic [hafr_pkg::STAT_W-1:0]       ost_reg, ost_next;
    logic [OW-1:0]                     ora_reg, ora_next;
    logic [DW-1:0]                     ord_reg, ord_next;
    logic [DW-1:0]                     olead_reg, olead_next;
    logic [DW-1:0]                     otrail_reg, otrail_next;
    logic [OW-1:0]                     oreqb_reg, oreqb_next;

    hafr_pkg::mem_req_t                mreq;
    logic [DW-1:0]                     q;

    logic [TW-1:0]   pay;
    logic [OW-1:0]   hdr_off;
    logic            bad;
    logic [TW-1:0]   cap;
    logic [TW+1:0]   ext_end;
    logic            ext_fail;
    logic [WW-1:0]   top_w;
    logic [WW-1:0]   hdr_w;
    logic [WW-1:0]   pay_w;
    logic [WW-1:0]   t_step;
    logic [WW-1:0]   ptr_step;
    logic [WW-1:0]   between;
    logic [WW-1:0]   step_between;
    logic [OW-1:0]   t_off;
    logic [OW-1:0]   trail_off;
    logic [OW-1:0]   split_off;
    logic [DW-1:0]   sz_minus_pay;
    logic [DW-1:0]   q_minus_pay;
    logic [WW-1:0]   between_minus_pay;
    logic [OW-1:0]   src_off;
    logic [OW-1:0]   dst_off;
    logic [4:0]      src_sh;
    logic [4:0]      dst_sh;

    hafr_mem u_mem (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (q)
    );

    assign pay               = hafr_pkg::round_payload(size_reg);
    assign hdr_off           = addr_reg - OW'(HB);
    assign bad               = (addr_reg < OW'(HB)) || ({1'b0, hdr_off} >= top_reg);
    assign cap               = (limit_reg < TW'(hafr_pkg::HEAP_BYTES)) ?
                               limit_reg : TW'(hafr_pkg::HEAP_BYTES);
    assign ext_end           = (TW+2)'(top_reg) + (TW+2)'(HB) + (TW+2)'(pay);
    assign ext_fail          = ext_end > (TW+2)'(cap);
    assign top_w             = WW'(top_reg);
    assign hdr_w             = WW'(h_reg);
    assign pay_w             = WW'(pay);
    assign t_step            = t_reg + WW'(HB) + WW'(sz_reg);
    assign ptr_step          = ptr_reg + WW'(HB) + WW'(q);
    assign between           = ptr_reg - hdr_w - WW'(HB);
    assign step_between      = ptr_step - hdr_w - WW'(HB);
    assign t_off             = t_reg[OW-1:0];
    assign trail_off         = t_off + OW'(HB - ZB) + cur_reg[OW-1:0];
    assign split_off         = t_off + OW'(HB) + pay[OW-1:0];
    assign sz_minus_pay      = sz_reg - DW'(pay);
    assign q_minus_pay       = q - DW'(pay);
    assign between_minus_pay = between - pay_w;
    assign src_off           = addr_reg + i_reg[OW-1:0];
    assign dst_off           = naddr_reg + i_reg[OW-1:0];
    assign src_sh            = {src_off[1:0], 3'b000};
    assign dst_sh            = {dst_off[1:0], 3'b000};

    assign req.ready         = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = ovalid_reg;
    assign rsp.status        = ost_reg;
    assign rsp.result_address = ora_reg;
    assign rsp.read_data     = ord_reg;
    assign rsp.leading_zone  = olead_reg;
    assign rsp.trailing_zone = otrail_reg;
    assign rsp.request_bytes = oreqb_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        wdata_next  = wdata_reg;
        top_next    = top_reg;
        limit_next  = limit_reg;
        t_next      = t_reg;
        ptr_next    = ptr_reg;
        h_next      = h_reg;
        sz_next     = sz_reg;
        cur_next    = cur_reg;
        mv_next     = mv_reg;
        inpl_next   = inpl_reg;
        naddr_next  = naddr_reg;
        len_next    = len_reg;
        i_next      = i_reg;
        byte_next   = byte_reg;
        st_next     = st_reg;
        ra_next     = ra_reg;
        rd_next     = rd_reg;
        lead_next   = lead_reg;
        trail_next  = trail_reg;
        reqb_next   = reqb_reg;
        ovalid_next = ovalid_reg;
        ost_next    = ost_reg;
        ora_next    = ora_reg;
        ord_next    = ord_reg;
        olead_next  = olead_reg;
        otrail_next = otrail_reg;
        oreqb_next  = oreqb_reg;
        mreq        = '0;

        if (cfg.valid)
        begin
            limit_next = cfg.heap_limit;
        end
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.req_type;
                    addr_next  = req.address;
                    size_next  = req.size;
                    wdata_next = req.write_data;
                    st_next    = hafr_pkg::ST_OK;
                    ra_next    = '0;
                    rd_next    = '0;
                    lead_next  = '0;
                    trail_next = '0;
                    reqb_next  = '0;
                    mv_next    = 1'b0;
                    inpl_next  = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (op_reg)
                    hafr_pkg::REQ_ALLOC:   state_next = S_AL_START;
                    hafr_pkg::REQ_FREE:    state_next = S_FR_START;
                    hafr_pkg::REQ_REALLOC: state_next = S_RA_START;
                    hafr_pkg::REQ_WRITE:
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = addr_reg[hafr_pkg::IDX_W-1:0];
                        mreq.wdata = wdata_reg;
                        state_next = S_FIN;
                    end
                    hafr_pkg::REQ_READ:
                    begin
                        mreq.re    = 1'b1;
                        mreq.raddr = addr_reg[hafr_pkg::IDX_W-1:0];
                        state_next = S_RD;
                    end
                    hafr_pkg::REQ_RESET:
                    begin
                        top_next   = '0;
                        state_next = S_FIN;
                    end
                    default:       state_next = S_FIN;
                endcase
            end
            S_RD:
            begin
                rd_next    = q;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = st_reg;
                    ora_next    = ra_reg;
                    ord_next    = rd_reg;
                    olead_next  = lead_reg;
                    otrail_next = trail_reg;
                    oreqb_next  = reqb_reg;
                    state_next  = S_IDLE;
                end
            end
            // first fit walk
            S_AL_START:
            begin
                if (size_reg == '0)
                begin
                    st_next    = hafr_pkg::ST_NOMEM;
                    state_next = mv_reg ? S_FR_START : S_FIN;
                end
                else
                begin
                    t_next     = '0;
                    state_next = S_AL_CHK;
                end
            end
            S_AL_CHK:
            begin
                if (t_reg < top_w)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(t_off);
                    state_next = S_AL_SZ;
                end
                else if (ext_fail)
                begin
                    st_next    = hafr_pkg::ST_NOMEM;
                    state_next = mv_reg ? S_FR_START : S_FIN;
                end
                else
                begin
                    t_next     = top_w;
                    top_next   = ext_end[TW-1:0];
                    cur_next   = DW'(pay);
                    mreq.we    = 1'b1;
                    mreq.waddr = hafr_pkg::word_idx(top_reg[OW-1:0]);
                    mreq.wdata = DW'(pay);
                    state_next = S_AL_W8;
                end
            end
            S_AL_SZ:
            begin
                sz_next    = q;
                mreq.re    = 1'b1;
                mreq.raddr = hafr_pkg::word_idx(t_off + OW'(4));
                state_next = S_AL_ST;
            end
            S_AL_ST:
            begin
                if ((sz_reg >= DW'(pay)) && (q == '0))
                begin
                    if (sz_minus_pay >= DW'(HB))
                    begin
                        cur_next   = DW'(pay);
                        state_next = S_SP1;
                    end
                    else
                    begin
                        cur_next   = sz_reg;
                        state_next = S_AL_W8;
                    end
                end
                else
                begin
                    t_next     = t_step;
                    state_next = S_AL_CHK;
                end
            end
            // split off the remainder
            S_SP1:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(split_off + OW'(4));
                mreq.wdata = '0;
                state_next = S_SP2;
            end
            S_SP2:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(split_off);
                mreq.wdata = sz_minus_pay - DW'(HB);
                state_next = S_SP3;
            end
            S_SP3:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(t_off);
                mreq.wdata = DW'(pay);
                state_next = inpl_reg ? S_RA_WT : S_AL_W8;
            end
            S_AL_W8:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(t_off + OW'(8));
                mreq.wdata = DW'(size_reg);
                state_next = S_AL_W4;
            end
            S_AL_W4:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(t_off + OW'(4));
                mreq.wdata = DW'(1);
                state_next = S_AL_W28;
            end
            S_AL_W28:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(t_off + OW'(HB - ZB));
                mreq.wdata = hafr_pkg::RED_ZONE;
                state_next = S_AL_WT;
            end
            S_AL_WT:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(trail_off);
                mreq.wdata = hafr_pkg::RED_ZONE;
                st_next    = hafr_pkg::ST_OK;
                ra_next    = t_off + OW'(HB);
                naddr_next = t_off + OW'(HB);
                state_next = mv_reg ? S_CP_RLEN : S_FIN;
            end
            // free with red zone check and forward merge
            S_FR_START:
            begin
                if (addr_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (bad)
                begin
                    st_next    = hafr_pkg::ST_NOT_USED;
                    state_next = S_FIN;
                end
                else
                begin
                    h_next     = hdr_off;
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(hdr_off + OW'(HB - ZB));
                    state_next = S_FR_LEAD;
                end
            end
            S_FR_LEAD:
            begin
                lead_next  = q;
                mreq.re    = 1'b1;
                mreq.raddr = hafr_pkg::word_idx(h_reg);
                state_next = S_FR_SIZE;
            end
            S_FR_SIZE:
            begin
                sz_next    = q;
                mreq.re    = 1'b1;
                mreq.raddr = hafr_pkg::word_idx(h_reg + OW'(HB - ZB) + q[OW-1:0]);
                state_next = S_FR_TRAIL;
            end
            S_FR_TRAIL:
            begin
                mreq.re = 1'b1;
                if ((lead_reg != hafr_pkg::RED_ZONE) || (q != hafr_pkg::RED_ZONE))
                begin
                    trail_next = q;
                    mreq.raddr = hafr_pkg::word_idx(h_reg + OW'(8));
                    state_next = S_FR_REQ;
                end
                else
                begin
                    lead_next  = '0;
                    mreq.raddr = hafr_pkg::word_idx(h_reg + OW'(4));
                    state_next = S_FR_STAT;
                end
            end
            S_FR_REQ:
            begin
                reqb_next  = q[OW-1:0];
                st_next    = hafr_pkg::ST_DAMAGED;
                state_next = S_FIN;
            end
            S_FR_STAT:
            begin
                if (q != DW'(1))
                begin
                    st_next    = hafr_pkg::ST_NOT_USED;
                    state_next = S_FIN;
                end
                else
                begin
                    ptr_next   = hdr_w + WW'(HB) + WW'(sz_reg);
                    state_next = S_FR_CHK;
                end
            end
            S_FR_CHK:
            begin
                if (ptr_reg < top_w)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(ptr_reg[OW-1:0] + OW'(4));
                    state_next = S_FR_NS;
                end
                else
                begin
                    state_next = S_FR_WH;
                end
            end
            S_FR_NS:
            begin
                if (q == '0)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(ptr_reg[OW-1:0]);
                    state_next = S_FR_NSZ;
                end
                else
                begin
                    state_next = S_FR_WH;
                end
            end
            S_FR_NSZ:
            begin
                ptr_next   = ptr_step;
                state_next = S_FR_CHK;
            end
            S_FR_WH:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(h_reg);
                mreq.wdata = between[DW-1:0];
                state_next = S_FR_W4;
            end
            S_FR_W4:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(h_reg + OW'(4));
                mreq.wdata = '0;
                state_next = S_FIN;
            end
            // realloc in place or move
            S_RA_START:
            begin
                if (addr_reg == '0)
                begin
                    state_next = S_AL_START;
                end
                else if (size_reg == '0)
                begin
                    state_next = S_FR_START;
                end
                else if (bad)
                begin
                    st_next    = hafr_pkg::ST_NOT_USED;
                    state_next = S_FIN;
                end
                else
                begin
                    h_next     = hdr_off;
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(hdr_off + OW'(4));
                    state_next = S_RA_STAT;
                end
            end
            S_RA_STAT:
            begin
                if (q != DW'(1))
                begin
                    st_next    = hafr_pkg::ST_NOT_USED;
                    state_next = S_FIN;
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(h_reg);
                    state_next = S_RA_SIZE;
                end
            end
            S_RA_SIZE:
            begin
                sz_next = q;
                t_next  = hdr_w;
                if (q >= DW'(pay))
                begin
                    if (q_minus_pay >= DW'(HB))
                    begin
                        cur_next   = DW'(pay);
                        inpl_next  = 1'b1;
                        state_next = S_SP1;
                    end
                    else
                    begin
                        state_next = S_RA_W8;
                    end
                end
                else
                begin
                    ptr_next   = hdr_w + WW'(HB) + WW'(q);
                    state_next = S_RA_CHK;
                end
            end
            S_RA_CHK:
            begin
                if (ptr_reg < top_w)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(ptr_reg[OW-1:0] + OW'(4));
                    state_next = S_RA_NS;
                end
                else
                begin
                    state_next = S_RA_DEC;
                end
            end
            S_RA_NS:
            begin
                if (q == '0)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(ptr_reg[OW-1:0]);
                    state_next = S_RA_NSZ;
                end
                else
                begin
                    state_next = S_RA_DEC;
                end
            end
            S_RA_NSZ:
            begin
                ptr_next   = ptr_step;
                state_next = (step_between >= pay_w) ? S_RA_DEC : S_RA_CHK;
            end
            S_RA_DEC:
            begin
                if (between >= pay_w)
                begin
                    sz_next = between[DW-1:0];
                    if (between_minus_pay >= WW'(HB))
                    begin
                        cur_next   = DW'(pay);
                        inpl_next  = 1'b1;
                        state_next = S_SP1;
                    end
                    else
                    begin
                        cur_next   = between[DW-1:0];
                        state_next = S_RA_WH;
                    end
                end
                else
                begin
                    mv_next    = 1'b1;
                    state_next = S_AL_START;
                end
            end
            S_RA_WH:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(h_reg);
                mreq.wdata = cur_reg;
                state_next = S_RA_WT;
            end
            S_RA_WT:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(trail_off);
                mreq.wdata = hafr_pkg::RED_ZONE;
                state_next = S_RA_W8;
            end
            S_RA_W8:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(h_reg + OW'(8));
                mreq.wdata = DW'(size_reg);
                ra_next    = addr_reg;
                state_next = S_FIN;
            end
            // byte copy into the new block
            S_CP_RLEN:
            begin
                mreq.re    = 1'b1;
                mreq.raddr = hafr_pkg::word_idx(h_reg + OW'(8));
                state_next = S_CP_LEN;
            end
            S_CP_LEN:
            begin
                len_next   = (q > DW'(hafr_pkg::HEAP_BYTES)) ?
                             TW'(hafr_pkg::HEAP_BYTES) : q[TW-1:0];
                i_next     = '0;
                state_next = S_CP_CHK;
            end
            S_CP_CHK:
            begin
                if (i_reg < len_reg)
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = hafr_pkg::word_idx(src_off);
                    state_next = S_CP_SRC;
                end
                else
                begin
                    state_next = S_FR_START;
                end
            end
            S_CP_SRC:
            begin
                byte_next  = 8'(q >> src_sh);
                mreq.re    = 1'b1;
                mreq.raddr = hafr_pkg::word_idx(dst_off);
                state_next = S_CP_DST;
            end
            S_CP_DST:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = hafr_pkg::word_idx(dst_off);
                mreq.wdata = (q & ~(DW'(8'hff) << dst_sh)) | (DW'(byte_reg) << dst_sh);
                i_next     = i_reg + TW'(1);
                state_next = S_CP_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            top_reg    <= '0;
            limit_reg  <= TW'(hafr_pkg::HEAP_BYTES);
            ovalid_reg <= 1'b0;
            mv_reg     <= 1'b0;
            inpl_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            limit_reg  <= limit_next;
            ovalid_reg <= ovalid_next;
            mv_reg     <= mv_next;
            inpl_reg   <= inpl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        size_reg   <= size_next;
        wdata_reg  <= wdata_next;
        t_reg      <= t_next;
        ptr_reg    <= ptr_next;
        h_reg      <= h_next;
        sz_reg     <= sz_next;
        cur_reg    <= cur_next;
        naddr_reg  <= naddr_next;
        len_reg    <= len_next;
        i_reg      <= i_next;
        byte_reg   <= byte_next;
        st_reg     <= st_next;
        ra_reg     <= ra_next;
        rd_reg     <= rd_next;
        lead_reg   <= lead_next;
        trail_reg  <= trail_next;
        reqb_reg   <= reqb_next;
        ost_reg    <= ost_next;
        ora_reg    <= ora_next;
        ord_reg    <= ord_next;
        olead_reg  <= olead_next;
        otrail_reg <= otrail_next;
        oreqb_reg  <= oreqb_next;
    end

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(hafr_pkg::HEAP_BYTES))
        else $error("heap top beyond heap size");

    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mreq.re && mreq.we))
        else $error("read and write issued together");

    a_copy_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CP_SRC) |-> (i_reg < len_reg))
        else $error("copy index past length");

    a_top_src: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg != $past(top_reg)) |->
        ($past(state_reg) == S_AL_CHK || $past(state_reg) == S_DISP))
        else $error("heap top changed outside extend or reset");

endmodule

`default_nettype wire
